FILE: src/mpi_pkg.sv
// ----------------------------------------------------------------------------
// mpi_pkg
// shared types and constants for the modular power and inverse unit
// ----------------------------------------------------------------------------
package mpi_pkg;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_MOD_ZERO    = 2'd1,
    ST_NOT_COPRIME = 2'd2,
    ST_MOD_SMALL   = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    OP_POW = 1'b0,
    OP_INV = 1'b1
  } opcode_e;

  // request and result payloads carried on the channels
  typedef struct packed {
    opcode_e      opcode;
    logic [31:0]  base;
    logic [31:0]  exponent;
    logic [31:0]  modulus;
  } pow_req_t;

  typedef struct packed {
    logic [31:0]  result;
    status_e      status;
  } pow_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_REDUCE,
    S_SQ_START,
    S_SQ_RUN,
    S_MUL_START,
    S_MUL_RUN,
    S_NEXT,
    S_GCD_START,
    S_GCD_RUN,
    S_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic red_step;
    logic sq_start;
    logic mul_start;
    logic mm_step;
    logic sq_wb;
    logic mul_wb;
    logic bit_next;
    logic gcd_start;
    logic gcd_step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic special;
    logic red_done;
    logic mm_done;
    logic cur_bit;
    logic last_bit;
    logic is_inv;
    logic gcd_done;
  } sts_t;

endpackage

FILE: src/mpi_if.sv
// ----------------------------------------------------------------------------
// mpi_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface mpi_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/mpi_ctrl.sv
// ----------------------------------------------------------------------------
// mpi_ctrl
// sequencer for reduction, square-and-multiply and gcd passes
// ----------------------------------------------------------------------------
module mpi_ctrl
  import mpi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts_i.special) state_d = S_OUT;
        else state_d = S_REDUCE;
      end
      S_REDUCE: begin
        cmd_o.red_step = 1'b1;
        if (sts_i.red_done) state_d = S_SQ_START;
      end
      S_SQ_START: begin
        cmd_o.sq_start = 1'b1;
        state_d        = S_SQ_RUN;
      end
      S_SQ_RUN: begin
        cmd_o.mm_step = 1'b1;
        if (sts_i.mm_done) begin
          cmd_o.sq_wb = 1'b1;
          state_d     = sts_i.cur_bit ? S_MUL_START : S_NEXT;
        end
      end
      S_MUL_START: begin
        cmd_o.mul_start = 1'b1;
        state_d         = S_MUL_RUN;
      end
      S_MUL_RUN: begin
        cmd_o.mm_step = 1'b1;
        if (sts_i.mm_done) begin
          cmd_o.mul_wb = 1'b1;
          state_d      = S_NEXT;
        end
      end
      S_NEXT: begin
        if (sts_i.last_bit) begin
          state_d = sts_i.is_inv ? S_GCD_START : S_OUT;
        end else begin
          cmd_o.bit_next = 1'b1;
          state_d        = S_SQ_START;
        end
      end
      S_GCD_START: begin
        cmd_o.gcd_start = 1'b1;
        state_d         = S_GCD_RUN;
      end
      S_GCD_RUN: begin
        cmd_o.gcd_step = 1'b1;
        if (sts_i.gcd_done) begin
          cmd_o.finish = 1'b1;
          state_d      = S_OUT;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  ap_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open together");
  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before taken");
  ap_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_LOAD)
    else $error("accepted request not loaded");

endmodule

FILE: src/mpi_dp.sv
// ----------------------------------------------------------------------------
// mpi_dp
// operand registers, shift-add modular multiplier, base reduction and gcd
// ----------------------------------------------------------------------------
module mpi_dp
  import mpi_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic             op_i,
  input  logic [WIDTH-1:0] base_i,
  input  logic [WIDTH-1:0] exponent_i,
  input  logic [WIDTH-1:0] modulus_i,
  output sts_t             sts_o,
  output logic [WIDTH-1:0] result_o,
  output logic [1:0]       status_o
);

  localparam int unsigned IW = $clog2(WIDTH);

  logic [WIDTH-1:0] b_q, e_q, m_q, r_q, bb_q;
  logic [WIDTH-1:0] ma_q, mb_q, acc_q;
  logic [WIDTH-1:0] ga_q, gb_q, gr_q;
  logic [IW-1:0]    bit_q, mi_q;
  logic [IW:0]      ri_q;
  logic [1:0]       st_q;
  logic             op_q, special_q, mm_busy_q;

  // (x + y) mod m with x, y < m
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[WIDTH-1:0];
  endfunction

  logic [WIDTH-1:0] fe, acc_dbl, acc_nxt;
  logic [WIDTH:0]   red_sh, gr_sh;
  logic             gcd_busy_q;

  assign fe      = modulus_i - WIDTH'(2);
  assign acc_dbl = add_mod(acc_q, acc_q, m_q);
  assign acc_nxt = mb_q[mi_q] ? add_mod(acc_dbl, ma_q, m_q) : acc_dbl;

  // restoring remainder steps: bb = b mod m, one bit per cycle
  always_comb begin
    red_sh = {bb_q, b_q[WIDTH-1]};
    if (red_sh >= {1'b0, m_q}) red_sh = red_sh - {1'b0, m_q};
  end
  always_comb begin
    gr_sh = {gr_q, ga_q[WIDTH-1]};
    if (gr_sh >= {1'b0, gb_q}) gr_sh = gr_sh - {1'b0, gb_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_busy_q  <= 1'b0;
      gcd_busy_q <= 1'b0;
      special_q  <= 1'b0;
      st_q       <= ST_OK;
      op_q       <= 1'b0;
      b_q        <= '0;
      e_q        <= '0;
      m_q        <= '0;
      r_q        <= '0;
      bb_q       <= '0;
      ma_q       <= '0;
      mb_q       <= '0;
      acc_q      <= '0;
      ga_q       <= '0;
      gb_q       <= '0;
      gr_q       <= '0;
      bit_q      <= '0;
      mi_q       <= '0;
      ri_q       <= '0;
    end else begin
      if (cmd_i.load) begin
        op_q       <= op_i;
        b_q        <= base_i;
        m_q        <= modulus_i;
        bb_q       <= '0;
        ri_q       <= '0;
        bit_q      <= IW'(WIDTH - 1);
        gcd_busy_q <= 1'b0;
        e_q        <= (op_i == OP_INV) ? fe : exponent_i;
        if (modulus_i == '0) begin
          special_q <= 1'b1; st_q <= ST_MOD_ZERO; r_q <= '0;
        end else if (op_i == OP_POW && exponent_i == '0) begin
          special_q <= 1'b1; st_q <= ST_OK; r_q <= WIDTH'(1);
        end else if (op_i == OP_INV && modulus_i == WIDTH'(1)) begin
          special_q <= 1'b1; st_q <= ST_MOD_SMALL; r_q <= '0;
        end else if (op_i == OP_INV && modulus_i == WIDTH'(2)) begin
          special_q <= 1'b1;
          st_q      <= base_i[0] ? ST_OK : ST_NOT_COPRIME;
          r_q       <= WIDTH'(1);
        end else begin
          special_q <= 1'b0; st_q <= ST_OK; r_q <= WIDTH'(1);
        end
      end
      if (cmd_i.red_step) begin
        bb_q <= red_sh[WIDTH-1:0];
        b_q  <= {b_q[WIDTH-2:0], 1'b0};
        ri_q <= ri_q + 1'b1;
        // r starts as 1 mod m
        if (m_q == WIDTH'(1)) r_q <= '0;
      end
      if (cmd_i.sq_start || cmd_i.mul_start) begin
        ma_q      <= cmd_i.sq_start ? r_q : bb_q;
        mb_q      <= r_q;
        acc_q     <= '0;
        mi_q      <= IW'(WIDTH - 1);
        mm_busy_q <= 1'b1;
      end else if (cmd_i.mm_step) begin
        acc_q <= acc_nxt;
        mi_q  <= mi_q - 1'b1;
        if (mi_q == '0) mm_busy_q <= 1'b0;
      end
      if (cmd_i.sq_wb || cmd_i.mul_wb) r_q <= acc_nxt;
      if (cmd_i.bit_next) bit_q <= bit_q - 1'b1;
      if (cmd_i.gcd_start) begin
        // b already shifted out; gcd(m, b mod m) equals gcd(b, m)
        ga_q       <= m_q;
        gb_q       <= bb_q;
        gr_q       <= '0;
        mi_q       <= IW'(WIDTH - 1);
        gcd_busy_q <= 1'b1;
      end else if (cmd_i.gcd_step) begin
        if (gb_q == '0) begin
          gcd_busy_q <= 1'b0;
          if (ga_q != WIDTH'(1)) st_q <= ST_NOT_COPRIME;
        end else if (mi_q == '0) begin
          // last remainder bit, then swap
          ga_q <= gb_q;
          gb_q <= gr_sh[WIDTH-1:0];
          gr_q <= '0;
          mi_q <= IW'(WIDTH - 1);
        end else begin
          // one remainder bit per cycle
          gr_q <= gr_sh[WIDTH-1:0];
          ga_q <= {ga_q[WIDTH-2:0], 1'b0};
          mi_q <= mi_q - 1'b1;
        end
      end
    end
  end

  assign sts_o.special  = special_q;
  assign sts_o.red_done = ri_q == (IW + 1)'(WIDTH - 1);
  assign sts_o.mm_done  = mi_q == '0 && mm_busy_q;
  assign sts_o.cur_bit  = e_q[bit_q];
  assign sts_o.last_bit = bit_q == '0;
  assign sts_o.is_inv   = op_q;
  assign sts_o.gcd_done = gcd_busy_q && gb_q == '0;
  assign result_o       = r_q;
  assign status_o       = st_q;

  ap_red_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.red_step) && !special_q |-> bb_q < m_q)
    else $error("reduced base not below modulus");
  ap_r_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.mul_wb) |-> r_q < m_q)
    else $error("product not reduced");
  ap_gcd_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> !gcd_busy_q)
    else $error("gcd still busy at finish");

endmodule

FILE: src/modular_power_and_inverse_unit.sv
// ----------------------------------------------------------------------------
// modular_power_and_inverse_unit
// base^exponent mod modulus, or Fermat inverse with gcd check
// ----------------------------------------------------------------------------
// sequence: load, base reduction, then per exponent bit a square and one more
//   multiply for a set bit; inverse then runs the euclid steps of the
//   bit-serial gcd (up to about 46 steps at WIDTH 32)
// zero modulus, zero exponent and small inverse moduli go to the result
//   straight after load
// throughput: one request in flight; the shared shift-add multiplier sets it
// reset: asynchronous active low, back to idle with no result pending
module modular_power_and_inverse_unit
  import mpi_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input logic clk_i,
  input logic rst_ni,
  mpi_if.sink   req,
  mpi_if.source rsp
);

  cmd_t cmd;
  sts_t sts;
  logic [WIDTH-1:0] res;
  logic [1:0]       st;

  // request payload: opcode, base, exponent, modulus
  mpi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mpi_dp #(.WIDTH(WIDTH)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .op_i       (req.data.opcode),
    .base_i     (WIDTH'(req.data.base)),
    .exponent_i (WIDTH'(req.data.exponent)),
    .modulus_i  (WIDTH'(req.data.modulus)),
    .sts_o      (sts),
    .result_o   (res),
    .status_o   (st)
  );

  // result held in the datapath until taken
  assign rsp.data.result = 32'(res);
  assign rsp.data.status = status_e'(st);

endmodule

FILE: test/tb_modular_power_and_inverse_unit.sv
// ----------------------------------------------------------------------------
// tb_modular_power_and_inverse_unit
// self-checking bench for the modular power and Fermat inverse unit: a
// directed table of corner cases, then random requests, all checked
// against a behavioral model of square-and-multiply and the gcd check
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_modular_power_and_inverse_unit;
  import mpi_pkg::*;

  localparam int unsigned WIDTH      = 32;
  localparam int          N_RANDOM   = 220;
  localparam int          CALM_AFTER = 200;     // no idling past this random index
  localparam int          HOLD_AT    = 120;     // sender waits for a drained pipe here
  localparam longint      LIMIT      = 6000000; // cycle cap for the whole run

  // one directed row; the typed-in result is used only where known is set
  typedef struct {
    opcode_e           opcode;
    logic [WIDTH-1:0]  base;
    logic [WIDTH-1:0]  exponent;
    logic [WIDTH-1:0]  modulus;
    bit                known;
    logic [WIDTH-1:0]  result;
    status_e           status;
  } row_t;

  logic clk_i;
  logic rst_ni;

  mpi_if #(.T(pow_req_t)) req_ch ();
  mpi_if #(.T(pow_rsp_t)) rsp_ch ();

  modular_power_and_inverse_unit #(.WIDTH(WIDTH)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  pow_rsp_t pending_q[$];   // results still owed by the unit
  int       mismatches = 0;
  bit       calm       = 1'b0;
  longint   cycles     = 0;
  int       ready_gap  = 0;

  task automatic report_mismatch(input string what, input logic [WIDTH-1:0] got,
                                 input logic [WIDTH-1:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic logic [WIDTH-1:0] mul_mod(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] m);
    logic [2*WIDTH-1:0] prod;
    prod = a * b;
    return WIDTH'(prod % m);
  endfunction

  // square-and-multiply from the top exponent bit, m nonzero
  function automatic logic [WIDTH-1:0] pow_mod(input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] e,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] acc;
    logic [WIDTH-1:0] bb;
    acc = 1 % m;
    bb  = b % m;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      acc = mul_mod(acc, acc, m);
      if (e[i]) acc = mul_mod(acc, bb, m);
    end
    return acc;
  endfunction

  function automatic logic [WIDTH-1:0] gcd_of(input logic [WIDTH-1:0] a,
                                              input logic [WIDTH-1:0] b);
    logic [WIDTH-1:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic pow_rsp_t predict_power(input pow_req_t rq);
    pow_rsp_t rs;
    rs.result = '0;
    rs.status = ST_OK;
    if (rq.modulus == 0) begin
      rs.status = ST_MOD_ZERO;
    end else if (rq.opcode == OP_POW) begin
      // zero exponent gives 1 even for modulus one
      rs.result = (rq.exponent == 0) ? 1 : pow_mod(rq.base, rq.exponent, rq.modulus);
    end else if (rq.modulus < 2) begin
      rs.status = ST_MOD_SMALL;
    end else begin
      rs.result = (rq.modulus == 2) ? 1 : pow_mod(rq.base, rq.modulus - 2, rq.modulus);
      if (gcd_of(rq.base, rq.modulus) != 1) rs.status = ST_NOT_COPRIME;
    end
    return rs;
  endfunction

  // ---------------------------------------------------------------------------
  // response side: random back-pressure in bursts, checking every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      ready_gap    <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected result", rsp_ch.data.result, '0);
        end else begin
          pow_rsp_t want;
          want = pending_q.pop_front();
          if (rsp_ch.data.result !== want.result)
            report_mismatch("result", rsp_ch.data.result, want.result);
          if (rsp_ch.data.status !== want.status)
            report_mismatch("status", WIDTH'(rsp_ch.data.status), WIDTH'(want.status));
        end
      end
      if (ready_gap > 0) begin
        ready_gap    <= ready_gap - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        ready_gap    <= $urandom_range(0, 5);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // present one request and hold it until taken; valid stays high afterwards
  task automatic send_request(input pow_req_t rq);
    req_ch.valid <= 1'b1;
    req_ch.data  <= rq;
    do @(posedge clk_i); while (!req_ch.ready);
    pending_q.push_back(predict_power(rq));
  endtask

  task automatic maybe_pause();
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 6);
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [WIDTH-1:0] pick_prime();
    logic [WIDTH-1:0] primes [8] = '{32'd3, 32'd5, 32'd7, 32'd65521, 32'd1000003,
                                     32'd2147483647, 32'd4294967291, 32'd97};
    return primes[$urandom_range(0, 7)];
  endfunction

  row_t table_rows [] = '{
    // modulus zero in both modes
    '{OP_POW, 32'd5, 32'd3, 32'd0, 1'b1, 32'd0, ST_MOD_ZERO},
    '{OP_INV, 32'hFFFFFFFF, 32'd0, 32'd0, 1'b1, 32'd0, ST_MOD_ZERO},
    // zero exponent, also with modulus one
    '{OP_POW, 32'd7, 32'd0, 32'd1, 1'b1, 32'd1, ST_OK},
    '{OP_POW, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 1'b1, 32'd1, ST_OK},
    '{OP_POW, 32'd7, 32'd5, 32'd1, 1'b1, 32'd0, ST_OK},
    // inverse with modulus one and two
    '{OP_INV, 32'd9, 32'd0, 32'd1, 1'b1, 32'd0, ST_MOD_SMALL},
    '{OP_INV, 32'd3, 32'hFFFFFFFF, 32'd2, 1'b1, 32'd1, ST_OK},
    '{OP_INV, 32'd4, 32'd0, 32'd2, 1'b1, 32'd1, ST_NOT_COPRIME},
    // small exact cases
    '{OP_POW, 32'd2, 32'd10, 32'd1000, 1'b1, 32'd24, ST_OK},
    '{OP_INV, 32'd3, 32'd0, 32'd7, 1'b1, 32'd5, ST_OK},
    '{OP_POW, 32'd0, 32'd1, 32'd13, 1'b1, 32'd0, ST_OK},
    // extremes, checked by the predictor
    '{OP_POW, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'd0, ST_OK},
    '{OP_POW, 32'hFFFFFFFE, 32'hFFFFFFFF, 32'hFFFFFFFB, 1'b0, 32'd0, ST_OK},
    '{OP_INV, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFB, 1'b0, 32'd0, ST_OK},
    '{OP_INV, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 1'b0, 32'd0, ST_OK},
    // not coprime inverse still yields a value
    '{OP_INV, 32'd6, 32'd0, 32'd9, 1'b0, 32'd0, ST_OK},
    '{OP_INV, 32'd0, 32'd0, 32'd65521, 1'b0, 32'd0, ST_OK},
    '{OP_POW, 32'd6, 32'd2, 32'd9, 1'b0, 32'd0, ST_OK},
    '{OP_POW, 32'h80000000, 32'h80000000, 32'h80000001, 1'b0, 32'd0, ST_OK}
  };

  initial begin
    pow_req_t rq;
    pow_rsp_t typed;
    int       kind;

    rst_ni       = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; typed-in values are cross-checked with the predictor
    foreach (table_rows[i]) begin
      rq = '{table_rows[i].opcode, table_rows[i].base, table_rows[i].exponent,
             table_rows[i].modulus};
      if (table_rows[i].known) begin
        typed = predict_power(rq);
        if (typed.result !== table_rows[i].result)
          report_mismatch("table result", typed.result, table_rows[i].result);
        if (typed.status !== table_rows[i].status)
          report_mismatch("table status", WIDTH'(typed.status),
                          WIDTH'(table_rows[i].status));
      end
      send_request(rq);
      maybe_pause();
    end

    // random part: mostly real work, some zero and tiny moduli
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == CALM_AFTER) calm = 1'b1;
      if (n == HOLD_AT) begin
        req_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk_i);
      end
      rq.opcode   = opcode_e'($urandom_range(0, 1));
      rq.base     = $urandom;
      rq.exponent = $urandom;
      kind        = $urandom_range(0, 9);
      if (kind < 4)       rq.modulus = pick_prime();
      else if (kind < 8)  rq.modulus = $urandom;
      else if (kind == 8) rq.modulus = $urandom_range(0, 3);
      else begin
        rq.modulus  = $urandom_range(2, 60);
        rq.base     = $urandom_range(0, 60);
        rq.exponent = $urandom_range(0, 3);
      end
      send_request(rq);
      maybe_pause();
    end
    req_ch.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
src/mpi_pkg.sv
src/mpi_if.sv
src/mpi_ctrl.sv
src/mpi_dp.sv
src/modular_power_and_inverse_unit.sv
test/tb_modular_power_and_inverse_unit.sv
